@@ design/iba_pkg.sv @@
// Shared types and constants for the inode and block bitmap allocator.
`timescale 1ns / 1ps
package iba_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;
   localparam int SIZE_W    = 32;
   localparam int CSR_W     = 13;
   localparam logic [CSR_W-1:0] CSR_RESET = 13'd3000;

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_RESIZE = 2'd1,
      MODE_FREE   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_INODE = 2'd1,
      ST_FULL     = 2'd2,
      ST_REFUSED  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_AI_RD,
      S_AI_CHK,
      S_RI_RD,
      S_RI_GET,
      S_REL_CHK,
      S_REL_WR,
      S_BM_RD,
      S_BM_GET,
      S_AL_NEED,
      S_AL_SRCH,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [6:0]        inode_index;
      logic [SIZE_W-1:0] req_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [6:0]        granted_inode;
      logic              block_valid;
      logic [11:0]       block_number;
      logic [3:0]        slot_number;
      logic [SIZE_W-1:0] stored_size;
      logic              last;
   } rsp_type;

endpackage

@@ design/iba_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module iba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/iba_ctrl.sv @@
// Request sequencer: inode table and block bitmap read-modify-write, result register.
`timescale 1ns / 1ps
module iba_ctrl #(
   parameter int INODE_COUNT     = 128,
   parameter int DIRECT_SLOTS    = 13,
   parameter int MAX_DATA_BLOCKS = 4096,
   parameter int BLOCK_BYTES     = 512,
   localparam int IA_W  = $clog2(INODE_COUNT),
   localparam int BLK_W = $clog2(MAX_DATA_BLOCKS),
   localparam int WORDS = (MAX_DATA_BLOCKS + iba_pkg::WORD_BITS - 1) / iba_pkg::WORD_BITS,
   localparam int WA_W  = $clog2(WORDS),
   localparam int MAP_W = DIRECT_SLOTS * BLK_W,
   localparam int ROW_W = 1 + iba_pkg::SIZE_W + MAP_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  iba_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output iba_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [iba_pkg::CSR_W-1:0]          csr_wdata,
   output logic                               ino_we,
   output logic [IA_W-1:0]                    ino_waddr,
   output logic [ROW_W-1:0]                   ino_wdata,
   output logic [IA_W-1:0]                    ino_raddr,
   input  logic [ROW_W-1:0]                   ino_rdata,
   output logic                               bm_we,
   output logic [WA_W-1:0]                    bm_waddr,
   output logic [iba_pkg::WORD_BITS-1:0]      bm_wdata,
   output logic [WA_W-1:0]                    bm_raddr,
   input  logic [iba_pkg::WORD_BITS-1:0]      bm_rdata
);

   localparam int SL_W  = $clog2(DIRECT_SLOTS + 1);
   localparam int MI_W  = (DIRECT_SLOTS > 1) ? $clog2(DIRECT_SLOTS) : 1;
   localparam int TH_W  = $clog2(DIRECT_SLOTS * BLOCK_BYTES + 1);
   localparam int CLR_N = (INODE_COUNT > WORDS) ? INODE_COUNT : WORDS;
   localparam int CLR_W = $clog2(CLR_N);
   localparam int SW    = iba_pkg::SIZE_W;
   localparam int WB    = iba_pkg::WORD_BITS;

   typedef logic [DIRECT_SLOTS-1:0][BLK_W-1:0] map_type;

   iba_pkg::state_type state_ff, state_in;
   iba_pkg::mode_type  mode_ff, mode_in;
   iba_pkg::status_type st_ff, st_in;
   iba_pkg::rsp_type   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [iba_pkg::CSR_W-1:0] count_ff, count_in;
   logic [CLR_W-1:0]          clr_ff, clr_in;
   logic [IA_W-1:0]           ino_ff, ino_in;
   logic [IA_W-1:0]           cnt_ff, cnt_in;
   logic [6:0]                gi_ff, gi_in;
   logic [SW-1:0]             req_size_ff, req_size_in;
   logic [SW-1:0]             size_ff, size_in;
   logic                      used_ff, used_in;
   map_type                   map_ff, map_in;
   logic [SL_W-1:0]           slot_ff, slot_in;
   logic [SL_W-1:0]           ecnt_ff, ecnt_in;
   logic                      extra_ff, extra_in;
   logic [TH_W-1:0]           thr_ff, thr_in;
   logic [WA_W-1:0]           widx_ff, widx_in;
   logic [WB-1:0]             word_ff, word_in;

   logic                      accept, refuse, rsp_load, slot_need, blk, last_res;
   logic                      q_used, found, more;
   logic [SW-1:0]             q_size, lim32, base32, rem32;
   map_type                   q_map;
   logic [MI_W-1:0]           slot_ix, ecnt_ix;
   logic [BLK_W-1:0]          cur_e, new_blk;
   logic [WB-1:0]             mask, free_bits;
   logic [iba_pkg::BIT_W-1:0] found_j;
   logic [31:0]               ino32;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != iba_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_load  = (state_ff == iba_pkg::S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign q_used = ino_rdata[ROW_W-1];
   assign q_size = ino_rdata[ROW_W-2 -: SW];
   assign q_map  = ino_rdata[MAP_W-1:0];

   assign ino32  = 32'(req_data.inode_index);
   assign refuse = (ino32 >= 32'(INODE_COUNT)) ||
                   ((req_data.mode == iba_pkg::MODE_FREE) && (req_data.inode_index == 7'd0));

   assign lim32  = (32'(count_ff) < 32'(MAX_DATA_BLOCKS)) ? 32'(count_ff)
                                                          : 32'(MAX_DATA_BLOCKS);
   assign base32 = 32'(widx_ff) << iba_pkg::BIT_W;
   assign rem32  = (lim32 > base32) ? (lim32 - base32) : 32'd0;
   assign mask   = (rem32 >= 32'(WB)) ? '1 : ((32'd1 << rem32[iba_pkg::BIT_W-1:0]) - 32'd1);
   assign free_bits = ~word_ff & mask;
   assign found  = |free_bits;
   assign more   = (base32 + 32'(WB)) < lim32;

   always_comb begin
      found_j = '0;
      for (int k = WB - 1; k >= 0; k--) begin
         if (free_bits[k]) begin
            found_j = iba_pkg::BIT_W'(k);
         end
      end
   end

   assign new_blk   = BLK_W'(base32 + 32'(found_j));
   assign slot_ix   = MI_W'(slot_ff);
   assign ecnt_ix   = MI_W'(ecnt_ff);
   assign cur_e     = map_ff[slot_ix];
   assign slot_need = (32'(slot_ff) < 32'(DIRECT_SLOTS)) && (size_ff > 32'(thr_ff));
   assign blk       = ecnt_ff < slot_ff;
   assign last_res  = extra_ff ? (ecnt_ff == slot_ff) : (SL_W'(ecnt_ff + 1'b1) == slot_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iba_pkg::S_CLEAR: begin
            if (32'(clr_ff) == 32'(CLR_N - 1)) state_in = iba_pkg::S_IDLE;
         end
         iba_pkg::S_IDLE: begin
            if (accept) begin
               if (req_data.mode == iba_pkg::MODE_NONE) state_in = iba_pkg::S_IDLE;
               else if (req_data.mode == iba_pkg::MODE_ALLOC) state_in = iba_pkg::S_AI_RD;
               else if (refuse) state_in = iba_pkg::S_EMIT;
               else state_in = iba_pkg::S_RI_RD;
            end
         end
         iba_pkg::S_AI_RD:  state_in = iba_pkg::S_AI_CHK;
         iba_pkg::S_AI_CHK: begin
            if (!q_used || (32'(cnt_ff) == 32'(INODE_COUNT - 1))) state_in = iba_pkg::S_EMIT;
            else state_in = iba_pkg::S_AI_RD;
         end
         iba_pkg::S_RI_RD:  state_in = iba_pkg::S_RI_GET;
         iba_pkg::S_RI_GET: state_in = iba_pkg::S_REL_CHK;
         iba_pkg::S_REL_CHK: begin
            if (slot_need) begin
               if (32'(cur_e) < lim32) state_in = iba_pkg::S_REL_WR;
            end else if (mode_ff == iba_pkg::MODE_FREE) begin
               state_in = iba_pkg::S_EMIT;
            end else begin
               state_in = iba_pkg::S_BM_RD;
            end
         end
         iba_pkg::S_REL_WR:  state_in = iba_pkg::S_REL_CHK;
         iba_pkg::S_BM_RD:   state_in = iba_pkg::S_BM_GET;
         iba_pkg::S_BM_GET:  state_in = iba_pkg::S_AL_NEED;
         iba_pkg::S_AL_NEED: state_in = slot_need ? iba_pkg::S_AL_SRCH : iba_pkg::S_EMIT;
         iba_pkg::S_AL_SRCH: begin
            if (found) state_in = iba_pkg::S_AL_NEED;
            else if (more) state_in = iba_pkg::S_BM_RD;
            else state_in = iba_pkg::S_EMIT;
         end
         iba_pkg::S_EMIT: begin
            if (rsp_load && last_res) state_in = iba_pkg::S_IDLE;
         end
         default: state_in = iba_pkg::S_CLEAR;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      mode_in     = mode_ff;
      st_in       = st_ff;
      clr_in      = clr_ff;
      ino_in      = ino_ff;
      cnt_in      = cnt_ff;
      gi_in       = gi_ff;
      req_size_in = req_size_ff;
      size_in     = size_ff;
      used_in     = used_ff;
      map_in      = map_ff;
      slot_in     = slot_ff;
      ecnt_in     = ecnt_ff;
      extra_in    = extra_ff;
      thr_in      = thr_ff;
      widx_in     = widx_ff;
      word_in     = word_ff;
      count_in    = csr_we ? csr_wdata : count_ff;
      ino_we      = 1'b0;
      ino_waddr   = ino_ff;
      ino_wdata   = {used_ff, size_ff, map_ff};
      ino_raddr   = (state_ff == iba_pkg::S_AI_RD) ? cnt_ff : ino_ff;
      bm_we       = 1'b0;
      bm_waddr    = widx_ff;
      bm_wdata    = word_ff;
      bm_raddr    = (state_ff == iba_pkg::S_BM_RD) ? widx_ff : WA_W'(cur_e >> iba_pkg::BIT_W);
      rsp_in      = rsp_ff;

      case (state_ff)
         iba_pkg::S_CLEAR: begin
            clr_in    = clr_ff + 1'b1;
            ino_we    = 32'(clr_ff) < 32'(INODE_COUNT);
            ino_waddr = IA_W'(clr_ff);
            ino_wdata = {(clr_ff == '0), {SW{1'b0}}, {MAP_W{1'b0}}};
            bm_we     = 32'(clr_ff) < 32'(WORDS);
            bm_waddr  = WA_W'(clr_ff);
            bm_wdata  = '0;
         end
         iba_pkg::S_IDLE: begin
            mode_in     = iba_pkg::mode_type'(req_data.mode);
            ino_in      = IA_W'(ino32);
            gi_in       = req_data.inode_index;
            req_size_in = req_data.req_bytes;
            cnt_in      = '0;
            size_in     = '0;
            slot_in     = '0;
            ecnt_in     = '0;
            extra_in    = 1'b1;
            st_in       = iba_pkg::ST_REFUSED;
         end
         iba_pkg::S_AI_CHK: begin
            cnt_in = cnt_ff + 1'b1;
            if (!q_used) begin
               ino_we    = 1'b1;
               ino_waddr = cnt_ff;
               ino_wdata = {1'b1, {SW{1'b0}}, q_map};
               gi_in     = 7'(cnt_ff);
               st_in     = iba_pkg::ST_OK;
            end else begin
               gi_in = '0;
               st_in = iba_pkg::ST_NO_INODE;
            end
         end
         iba_pkg::S_RI_GET: begin
            used_in = q_used;
            size_in = q_size;
            map_in  = q_map;
            slot_in = '0;
            thr_in  = '0;
         end
         iba_pkg::S_REL_CHK: begin
            if (slot_need) begin
               if (32'(cur_e) >= lim32) begin
                  slot_in = slot_ff + 1'b1;
                  thr_in  = thr_ff + TH_W'(BLOCK_BYTES);
               end
            end else if (mode_ff == iba_pkg::MODE_FREE) begin
               ino_we    = 1'b1;
               ino_wdata = {1'b0, {SW{1'b0}}, map_ff};
               size_in   = '0;
               slot_in   = '0;
               extra_in  = 1'b1;
               st_in     = iba_pkg::ST_OK;
            end else begin
               size_in = req_size_ff;
               slot_in = '0;
               thr_in  = '0;
               widx_in = '0;
            end
         end
         iba_pkg::S_REL_WR: begin
            bm_we    = 1'b1;
            bm_waddr = WA_W'(cur_e >> iba_pkg::BIT_W);
            bm_wdata = bm_rdata & ~(WB'(1) << cur_e[iba_pkg::BIT_W-1:0]);
            slot_in  = slot_ff + 1'b1;
            thr_in   = thr_ff + TH_W'(BLOCK_BYTES);
         end
         iba_pkg::S_BM_GET: word_in = bm_rdata;
         iba_pkg::S_AL_NEED: begin
            if (!slot_need) begin
               bm_we    = 1'b1;
               ino_we   = 1'b1;
               extra_in = (slot_ff == '0);
               st_in    = iba_pkg::ST_OK;
            end
         end
         iba_pkg::S_AL_SRCH: begin
            if (found) begin
               word_in[found_j] = 1'b1;
               map_in[slot_ix]  = new_blk;
               slot_in          = slot_ff + 1'b1;
               thr_in           = thr_ff + TH_W'(BLOCK_BYTES);
            end else begin
               bm_we = 1'b1;
               if (more) begin
                  widx_in = widx_ff + 1'b1;
               end else begin
                  size_in   = SW'(thr_ff);
                  ino_we    = 1'b1;
                  ino_wdata = {used_ff, SW'(thr_ff), map_ff};
                  extra_in  = 1'b1;
                  st_in     = iba_pkg::ST_FULL;
               end
            end
         end
         iba_pkg::S_EMIT: begin
            if (rsp_load) begin
               ecnt_in              = ecnt_ff + 1'b1;
               rsp_in.status        = blk ? iba_pkg::ST_OK : st_ff;
               rsp_in.granted_inode = gi_ff;
               rsp_in.block_valid   = blk;
               rsp_in.block_number  = blk ? 12'(map_ff[ecnt_ix]) : 12'd0;
               rsp_in.slot_number   = blk ? 4'(ecnt_ff) : 4'd0;
               rsp_in.stored_size   = size_ff;
               rsp_in.last          = last_res;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iba_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= iba_pkg::CSR_RESET;
         slot_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
      end
      mode_ff     <= mode_in;
      st_ff       <= st_in;
      rsp_ff      <= rsp_in;
      ino_ff      <= ino_in;
      cnt_ff      <= cnt_in;
      gi_ff       <= gi_in;
      req_size_ff <= req_size_in;
      size_ff     <= size_in;
      used_ff     <= used_in;
      map_ff      <= map_in;
      ecnt_ff     <= ecnt_in;
      extra_ff    <= extra_in;
      thr_ff      <= thr_in;
      widx_ff     <= widx_in;
      word_ff     <= word_in;
   end

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iba_pkg::S_CLEAR) |-> !rsp_valid_ff)
      else $error("result presented during clearing pass");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) <= 32'(DIRECT_SLOTS))
      else $error("slot counter beyond direct limit");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == iba_pkg::S_AL_SRCH) && found) |-> ((base32 + 32'(found_j)) < lim32))
      else $error("allocated block beyond usable count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.mode != iba_pkg::MODE_NONE)) |=> (state_ff != iba_pkg::S_IDLE))
      else $error("request accepted but not processed");

endmodule

@@ design/inode_block_bitmap_allocator.sv @@
// Top level: first-fit inode and data-block allocator.
// Usage:
//   req_* channel carries one request (allocate, resize, free) per transfer;
//   rsp_* channel returns one or more results, the final one with last set.
//   csr_we/csr_wdata write the usable data block count (3000 after reset).
// Storage: an inode table RAM (used bit, size, direct map per inode) and a
//   block bitmap RAM of 32-bit words, both with registered read data.
// After reset a clearing pass over max(INODE_COUNT, MAX_DATA_BLOCKS/32) addresses
//   (128 by default) runs; req_stall stays high until it ends.
// Requests are handled one at a time; req_stall is low only when idle.
//   Allocate: scans the inode table in order for the first unused inode.
//   Free: releases the blocks covered by the size (entries past the usable
//     count are skipped), clears the inode, then presents the result.
//   Resize: releases the old blocks, then searches the bitmap word by word,
//     taking free blocks until the new size is covered or the disk fills.
//   The bitmap RAM port is shared by release and search.
// Results go through an output register; while rsp_stall is high the held
//   result stays and the sequencer waits, then resumes the next result.
`timescale 1ns / 1ps
module inode_block_bitmap_allocator #(
   parameter int INODE_COUNT     = 128,
   parameter int DIRECT_SLOTS    = 13,
   parameter int MAX_DATA_BLOCKS = 4096,
   parameter int BLOCK_BYTES     = 512
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  iba_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output iba_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [iba_pkg::CSR_W-1:0] csr_wdata
);

   localparam int IA_W  = $clog2(INODE_COUNT);
   localparam int BLK_W = $clog2(MAX_DATA_BLOCKS);
   localparam int WORDS = (MAX_DATA_BLOCKS + iba_pkg::WORD_BITS - 1) / iba_pkg::WORD_BITS;
   localparam int WA_W  = $clog2(WORDS);
   localparam int ROW_W = 1 + iba_pkg::SIZE_W + DIRECT_SLOTS * BLK_W;

   logic                          ino_we, bm_we;
   logic [IA_W-1:0]               ino_waddr, ino_raddr;
   logic [ROW_W-1:0]              ino_wdata, ino_rdata;
   logic [WA_W-1:0]               bm_waddr, bm_raddr;
   logic [iba_pkg::WORD_BITS-1:0] bm_wdata, bm_rdata;

   iba_ctrl #(
      .INODE_COUNT    (INODE_COUNT),
      .DIRECT_SLOTS   (DIRECT_SLOTS),
      .MAX_DATA_BLOCKS(MAX_DATA_BLOCKS),
      .BLOCK_BYTES    (BLOCK_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .ino_we   (ino_we),
      .ino_waddr(ino_waddr),
      .ino_wdata(ino_wdata),
      .ino_raddr(ino_raddr),
      .ino_rdata(ino_rdata),
      .bm_we    (bm_we),
      .bm_waddr (bm_waddr),
      .bm_wdata (bm_wdata),
      .bm_raddr (bm_raddr),
      .bm_rdata (bm_rdata)
   );

   iba_ram #(
      .WIDTH(ROW_W),
      .DEPTH(INODE_COUNT)
   ) u_inode_ram (
      .clock(clock),
      .we   (ino_we),
      .waddr(ino_waddr),
      .wdata(ino_wdata),
      .raddr(ino_raddr),
      .rdata(ino_rdata)
   );

   iba_ram #(
      .WIDTH(iba_pkg::WORD_BITS),
      .DEPTH(WORDS)
   ) u_bitmap_ram (
      .clock(clock),
      .we   (bm_we),
      .waddr(bm_waddr),
      .wdata(bm_wdata),
      .raddr(bm_raddr),
      .rdata(bm_rdata)
   );

endmodule
